/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands; the including scope provides clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

/* hw/rtl/hlsd_pkg.sv */
// ----------------------------------------------------------------------------
// hlsd_pkg
// Shared types and constants of the header/length/sum deframer.
// ----------------------------------------------------------------------------
package hlsd_pkg;

	localparam int unsigned MAX_FRAME_LEN_DEF = 256;
	localparam int unsigned MIN_FRAME_LEN     = 6;
	localparam int unsigned QUEUE_DEPTH       = 2;

	localparam logic [7:0]  HDR_FIRST         = 8'h4E;
	localparam logic [7:0]  HDR_SECOND        = 8'h58;
	localparam logic [15:0] GAP_TIMEOUT_RESET = 16'd1000;
	localparam logic        REG_GAP_TIMEOUT   = 1'b0;

	typedef enum logic [0:0] {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_OK      = 2'd1,
		KIND_SUM_ERR = 2'd2,
		KIND_ABORT   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_HUNT      = 3'd0,
		PH_GOT_FIRST = 3'd1,
		PH_LEN_HIGH  = 3'd2,
		PH_LEN_LOW   = 3'd3,
		PH_COMMAND   = 3'd4,
		PH_BODY      = 3'd5
	} phase_t;

	typedef struct packed {
		logic       accept;
		op_t        operation;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_value;
		logic [7:0] command_code;
		logic [7:0] position;
	} res_t;

	typedef struct packed {
		logic valid;
		res_t res;
	} push_t;

endpackage

/* hw/rtl/hlsd_if.sv */
// ----------------------------------------------------------------------------
// hlsd_in_if / hlsd_out_if
// Valid/ready channels for received items and result items.
// ----------------------------------------------------------------------------
interface hlsd_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] data_byte;

	modport source (output valid, output operation, output data_byte, input ready);
	modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface hlsd_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_value;
	logic [7:0] command_code;
	logic [7:0] position;

	modport source (output valid, output kind, output data_value, output command_code,
		output position, input ready);
	modport sink (input valid, input kind, input data_value, input command_code,
		input position, output ready);
endinterface

/* hw/rtl/header_length_sum_deframer.sv */
// ----------------------------------------------------------------------------
// header_length_sum_deframer
// Byte-serial "NX" frame deframer with length check, sum checksum and gap timeout.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result queue is not full: received bytes and
// timer ticks on the link channel, payload bytes and end-of-frame status on the
// frame channel. An accepted item is parsed in the cycle it arrives and its
// result, if any, enters the result queue at that clock edge; with the queue
// empty it is on the frame channel the next cycle. The two-entry queue sits
// between the parser and the frame channel; link.ready drops while it is full,
// so once results come back to back any frame channel stall also stalls the link.
// Frame length accepted is 6..MAX_FRAME_LEN. gap_timeout_ticks sits at address 0
// and is to be written only while the block is idle.

module header_length_sum_deframer import hlsd_pkg::*; #(
	parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	hlsd_in_if.sink     link,
	hlsd_out_if.source  frame
);

	logic [15:0] gap_timeout_q;
	logic        reg_hit;
	logic        full;
	in_item_t    item;
	push_t       push;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_GAP_TIMEOUT) && (paddr[1:0] == 2'b00);
	assign prdata  = reg_hit ? {16'd0, gap_timeout_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_timeout_q <= GAP_TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_GAP_TIMEOUT)) begin
			gap_timeout_q <= pwdata[15:0];
		end
	end

	assign link.ready     = !full;
	assign item.accept    = link.valid && link.ready;
	assign item.operation = op_t'(link.operation);
	assign item.data_byte = link.data_byte;

	hlsd_front #(
		.MAX_FRAME_LEN(MAX_FRAME_LEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.gap_timeout(gap_timeout_q),
		.push       (push)
	);

	hlsd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.frame (frame)
	);

endmodule

/* hw/rtl/hlsd_front.sv */
// ----------------------------------------------------------------------------
// hlsd_front
// Frame parser: tracks header, length, command and body, emits result items.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hlsd_front import hlsd_pkg::*; #(
	parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  in_item_t    item,
	input  logic [15:0] gap_timeout,
	output push_t       push
);

	localparam int unsigned LW = $clog2(MAX_FRAME_LEN + 1);
	localparam int unsigned PW = (LW > 8) ? LW : 8;
	localparam logic [7:0]  SUM_INIT = HDR_FIRST + HDR_SECOND;

	phase_t          phase_q, phase_d;
	logic [7:0]      len_high_q;
	logic [LW-1:0]   frame_length_q;
	logic [LW-1:0]   byte_count_q;
	logic [7:0]      sum_q;
	logic [7:0]      cmd_q;
	logic [15:0]     idle_q;

	logic [7:0]      b;
	logic            is_tick;
	logic [15:0]     len;
	logic            len_ok;
	logic            restart;
	logic [15:0]     idle_inc;
	logic            timeout;
	logic            last_byte;
	logic [PW-1:0]   bc_ext, fl_ext, pos_body, pos_end, pos_abort;

	assign b         = item.data_byte;
	assign is_tick   = (item.operation == OP_TICK);
	assign len       = {len_high_q, b};
	assign len_ok    = (len >= 16'(MIN_FRAME_LEN)) && (len <= 16'(MAX_FRAME_LEN));
	assign restart   = (len_high_q == HDR_FIRST) && (b == HDR_SECOND);
	assign idle_inc  = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;
	assign timeout   = (phase_q != PH_HUNT) && (idle_inc > gap_timeout);
	assign last_byte = ({1'b0, byte_count_q} + {{LW{1'b0}}, 1'b1}) >= {1'b0, frame_length_q};

	assign bc_ext    = PW'(byte_count_q);
	assign fl_ext    = PW'(frame_length_q);
	assign pos_body  = bc_ext - PW'(5);
	assign pos_end   = fl_ext - PW'(MIN_FRAME_LEN);
	assign pos_abort = (bc_ext > PW'(5)) ? pos_body : '0;

	// next state
	always_comb begin
		phase_d = phase_q;
		if (item.accept) begin
			if (is_tick) begin
				if (timeout) begin
					phase_d = PH_HUNT;
				end
			end else begin
				unique case (phase_q)
					PH_HUNT: begin
						phase_d = (b == HDR_FIRST) ? PH_GOT_FIRST : PH_HUNT;
					end
					PH_GOT_FIRST: begin
						if (b == HDR_SECOND) begin
							phase_d = PH_LEN_HIGH;
						end else if (b != HDR_FIRST) begin
							phase_d = PH_HUNT;
						end
					end
					PH_LEN_HIGH: begin
						phase_d = PH_LEN_LOW;
					end
					PH_LEN_LOW: begin
						if (len_ok) begin
							phase_d = PH_COMMAND;
						end else if (restart) begin
							phase_d = PH_LEN_HIGH;
						end else if (b == HDR_FIRST) begin
							phase_d = PH_GOT_FIRST;
						end else begin
							phase_d = PH_HUNT;
						end
					end
					PH_COMMAND: begin
						phase_d = PH_BODY;
					end
					PH_BODY: begin
						if (last_byte) begin
							phase_d = PH_HUNT;
						end
					end
					default: begin
						phase_d = PH_HUNT;
					end
				endcase
			end
		end
	end

	// result items
	always_comb begin
		push = '0;
		if (item.accept) begin
			if (is_tick) begin
				if (timeout && (phase_q != PH_GOT_FIRST)) begin
					push.valid            = 1'b1;
					push.res.kind         = KIND_ABORT;
					push.res.command_code = cmd_q;
					push.res.position     = pos_abort[7:0];
				end
			end else if (phase_q == PH_BODY) begin
				push.valid             = 1'b1;
				push.res.data_value    = b;
				push.res.command_code  = cmd_q;
				if (last_byte) begin
					push.res.kind     = (b == sum_q) ? KIND_OK : KIND_SUM_ERR;
					push.res.position = pos_end[7:0];
				end else begin
					push.res.kind     = KIND_PAYLOAD;
					push.res.position = pos_body[7:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			len_high_q     <= '0;
			frame_length_q <= '0;
			byte_count_q   <= '0;
			sum_q          <= '0;
			cmd_q          <= '0;
			idle_q         <= '0;
		end else begin
			phase_q <= phase_d;
			if (item.accept) begin
				if (is_tick) begin
					idle_q <= idle_inc;
				end else begin
					idle_q <= '0;
					case (phase_q)
						PH_GOT_FIRST: begin
							if (b == HDR_SECOND) begin
								sum_q          <= SUM_INIT;
								byte_count_q   <= LW'(2);
								cmd_q          <= '0;
								frame_length_q <= '0;
							end
						end
						PH_LEN_HIGH: begin
							len_high_q   <= b;
							sum_q        <= sum_q + b;
							byte_count_q <= LW'(3);
						end
						PH_LEN_LOW: begin
							if (len_ok) begin
								frame_length_q <= LW'(len);
								sum_q          <= sum_q + b;
								byte_count_q   <= LW'(4);
							end else if (restart) begin
								sum_q          <= SUM_INIT;
								byte_count_q   <= LW'(2);
								cmd_q          <= '0;
								frame_length_q <= '0;
							end
						end
						PH_COMMAND: begin
							cmd_q        <= b;
							sum_q        <= sum_q + b;
							byte_count_q <= LW'(5);
						end
						PH_BODY: begin
							if (!last_byte) begin
								sum_q        <= sum_q + b;
								byte_count_q <= byte_count_q + LW'(1);
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	`ASSERT_CLK(a_body_count, (phase_q == PH_BODY) |-> (byte_count_q < frame_length_q), "body count past frame end")
	`ASSERT_CLK(a_cmd_len, (phase_q == PH_COMMAND) |-> (frame_length_q >= LW'(MIN_FRAME_LEN)), "short frame accepted")
	`ASSERT_CLK(a_end_hunt, (push.valid && (push.res.kind != KIND_PAYLOAD)) |=> (phase_q == PH_HUNT), "no hunt after frame end")

endmodule

/* hw/rtl/hlsd_queue.sv */
// ----------------------------------------------------------------------------
// hlsd_queue
// Short result queue; its head drives the result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hlsd_queue import hlsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  push_t             push,
	output logic              full,
	hlsd_out_if.source        frame
);

	localparam int unsigned PTRW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW   = $clog2(QUEUE_DEPTH + 1);

	res_t            entry_q [QUEUE_DEPTH];
	logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            pop;
	res_t            head;

	assign full               = (count_q == CW'(QUEUE_DEPTH));
	assign head               = entry_q[rd_ptr_q];
	assign frame.valid        = (count_q != '0);
	assign frame.kind         = head.kind;
	assign frame.data_value   = head.data_value;
	assign frame.command_code = head.command_code;
	assign frame.position     = head.position;
	assign pop                = frame.valid && frame.ready;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + PTRW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTRW'(1);
			end
			case ({push.valid, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_NEVER(a_no_overflow, push.valid && full, "push into full queue")
	`ASSERT_CLK(a_drain, (pop && !push.valid && (count_q == CW'(1))) |=> (count_q == '0), "queue not drained")
	`ASSERT_CLK(a_count_max, count_q <= CW'(QUEUE_DEPTH), "queue count past depth")

endmodule

/* bench/deframer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframer_checker
// Passive scoreboard for the NX deframer. It follows register writes and
// accepted link items, runs its own copy of the parser state and checks each
// accepted frame item, field by field, against the oldest predicted one.
// ----------------------------------------------------------------------------
module deframer_checker import hlsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	hlsd_in_if          link,
	hlsd_out_if         frame,
	output int          mismatches,
	output int          outstanding,
	output int          payload_seen,
	output int          frames_ok,
	output int          sum_errors,
	output int          aborts
);
	localparam logic [2:0] GAP_ADDR = 3'(REG_GAP_TIMEOUT) << 2;

	logic [15:0] gap_limit;
	phase_t      phase;
	logic [7:0]  len_high;
	logic [8:0]  frame_size;
	logic [8:0]  taken;
	logic [7:0]  sum;
	logic [7:0]  cmd;
	logic [15:0] idle;
	res_t        awaited_items[$];

	task automatic open_frame();
		sum        = HDR_FIRST + HDR_SECOND;
		taken      = 9'd2;
		cmd        = 8'h00;
		frame_size = 9'd0;
		phase      = PH_LEN_HIGH;
	endtask

	task automatic deframe(input op_t op, input logic [7:0] b);
		logic [15:0] len;
		res_t        r;
		len = {len_high, b};
		if (op == OP_TICK) begin
			if (idle != 16'hFFFF)
				idle++;
			if (phase != PH_HUNT && idle > gap_limit) begin
				if (phase != PH_GOT_FIRST) begin
					r.kind         = KIND_ABORT;
					r.data_value   = 8'h00;
					r.command_code = cmd;
					r.position     = (taken > 9'd5) ? 8'(taken - 9'd5) : 8'h00;
					awaited_items.push_back(r);
				end
				phase = PH_HUNT;
			end
		end else begin
			idle = '0;
			case (phase)
			PH_HUNT: begin
				if (b == HDR_FIRST)
					phase = PH_GOT_FIRST;
			end
			PH_GOT_FIRST: begin
				if (b == HDR_SECOND)
					open_frame();
				else if (b != HDR_FIRST)
					phase = PH_HUNT;
			end
			PH_LEN_HIGH: begin
				len_high = b;
				sum += b;
				taken = 9'd3;
				phase = PH_LEN_LOW;
			end
			PH_LEN_LOW: begin
				if (len >= MIN_FRAME_LEN && len <= MAX_FRAME_LEN_DEF) begin
					frame_size = len[8:0];
					sum += b;
					taken = 9'd4;
					phase = PH_COMMAND;
				end else if (len_high == HDR_FIRST && b == HDR_SECOND) begin
					open_frame();
				end else if (b == HDR_FIRST) begin
					phase = PH_GOT_FIRST;
				end else begin
					phase = PH_HUNT;
				end
			end
			PH_COMMAND: begin
				cmd = b;
				sum += b;
				taken = 9'd5;
				phase = PH_BODY;
			end
			PH_BODY: begin
				r.data_value   = b;
				r.command_code = cmd;
				if (taken + 9'd1 >= frame_size) begin
					r.kind     = (b == sum) ? KIND_OK : KIND_SUM_ERR;
					r.position = 8'(frame_size - 9'd6);
					phase = PH_HUNT;
				end else begin
					r.kind     = KIND_PAYLOAD;
					r.position = 8'(taken - 9'd5);
					sum += b;
					taken++;
				end
				awaited_items.push_back(r);
			end
			default: phase = PH_HUNT;
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t got;
		res_t want;
		if (!arst_n) begin
			gap_limit    = GAP_TIMEOUT_RESET;
			phase        = PH_HUNT;
			len_high     = '0;
			frame_size   = '0;
			taken        = '0;
			sum          = '0;
			cmd          = '0;
			idle         = '0;
			awaited_items.delete();
			mismatches   = 0;
			outstanding  = 0;
			payload_seen = 0;
			frames_ok    = 0;
			sum_errors   = 0;
			aborts       = 0;
		end else begin
			if (frame.valid && frame.ready) begin
				got.kind         = kind_t'(frame.kind);
				got.data_value   = frame.data_value;
				got.command_code = frame.command_code;
				got.position     = frame.position;
				if (awaited_items.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected frame item kind %0d value %02h cmd %02h pos %0d",
							$time, got.kind, got.data_value, got.command_code, got.position);
				end else begin
					want = awaited_items.pop_front();
					if (got.kind !== want.kind || got.data_value !== want.data_value ||
						got.command_code !== want.command_code ||
						got.position !== want.position) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: frame item expected kind %0d value %02h cmd %02h pos %0d, %s",
								$time, want.kind, want.data_value, want.command_code,
								want.position,
								$sformatf("got kind %0d value %02h cmd %02h pos %0d",
									got.kind, got.data_value, got.command_code, got.position));
					end
					case (want.kind)
					KIND_PAYLOAD: payload_seen++;
					KIND_OK:      frames_ok++;
					KIND_SUM_ERR: sum_errors++;
					default:      aborts++;
					endcase
				end
			end
			if (psel && penable && pwrite && pready && paddr == GAP_ADDR)
				gap_limit = pwdata[15:0];
			if (link.valid && link.ready)
				deframe(op_t'(link.operation), link.data_byte);
			outstanding = awaited_items.size();
		end
	end
endmodule

/* bench/header_length_sum_deframer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_length_sum_deframer_test
// Drives NX frames, noise and timer ticks into the deframer: a few hand-built
// frames first, then random frames (good, bad length, bad sum, cut short)
// under three sender/receiver idling mixes and several gap timeouts, ending
// with a frame held open under the largest timeout. Frame items are checked by
// deframer_checker.
// ----------------------------------------------------------------------------
module header_length_sum_deframer_test;
	import hlsd_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	localparam int         CYCLE_LIMIT = 600000;
	localparam logic [2:0] GAP_ADDR    = 3'(REG_GAP_TIMEOUT) << 2;
	localparam logic [2:0] SPARE_ADDR  = 3'(REG_GAP_TIMEOUT + 1) << 2;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        rx_hold;
	logic        hold_go = 1'b0;

	int cycle_count  = 0;
	int items_sent   = 0;
	int items_goal   = 0;
	int cur_gap      = GAP_TIMEOUT_RESET;
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int mismatches;
	int outstanding;
	int payload_seen;
	int frames_ok;
	int sum_errors;
	int aborts;

	hlsd_in_if  link ();
	hlsd_out_if frame ();

	header_length_sum_deframer DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.link    (link),
		.frame   (frame)
	);

	deframer_checker monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.link         (link),
		.frame        (frame),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.payload_seen (payload_seen),
		.frames_ok    (frames_ok),
		.sum_errors   (sum_errors),
		.aborts       (aborts)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[header_length_sum_deframer] ERROR");
			$finish;
		end
	end

	initial begin
		frame.ready <= 1'b0;
		forever begin
			@(posedge clk);
			frame.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// long receiver hold-off so the result queue fills and the link stalls
	initial begin
		rx_hold = 1'b0;
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rx_hold <= 1'b0;
	end

	task automatic offer(input op_t op, input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			link.valid <= 1'b0;
			@(posedge clk);
		end
		link.valid     <= 1'b1;
		link.operation <= op;
		link.data_byte <= b;
		do @(posedge clk); while (!link.ready);
		items_sent++;
	endtask

	task automatic put_byte(input logic [7:0] b);
		offer(OP_BYTE, b);
	endtask

	task automatic put_ticks(input int n);
		repeat (n) offer(OP_TICK, 8'($urandom_range(255)));
	endtask

	task automatic send_bytes(input byte_q_t seq);
		foreach (seq[i])
			put_byte(seq[i]);
	endtask

	task automatic settle();
		link.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_gap(input logic [15:0] ticks);
		settle();
		reg_write(GAP_ADDR, {16'h0000, ticks});
		cur_gap = ticks;
	endtask

	task automatic send_frame();
		byte_q_t     body;
		logic [15:0] len;
		logic [7:0]  chk;
		int          style;
		int          cut;
		style = $urandom_range(11);
		if ($urandom_range(39) == 0)
			len = 16'd256;
		else if ($urandom_range(29) == 0)
			len = 16'($urandom_range(100, 255));
		else
			len = 16'($urandom_range(6, 20));
		if (style == 0) begin
			case ($urandom_range(3))
			0: len = 16'($urandom_range(0, 5));
			1: len = 16'($urandom_range(257, 65535));
			2: len = {HDR_FIRST, HDR_SECOND};
			default: len = {8'($urandom_range(1, 255)), HDR_FIRST};
			endcase
		end
		if (style == 1)
			put_byte(HDR_FIRST);
		if (style == 4)
			repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(255)));
		body = '{HDR_FIRST, HDR_SECOND, len[15:8], len[7:0], 8'($urandom_range(255))};
		repeat ((len >= 6 && len <= 256) ? len - 6 : $urandom_range(6))
			body.push_back(8'($urandom_range(255)));
		chk = '0;
		foreach (body[i])
			chk += body[i];
		if (style == 2)
			chk ^= 8'($urandom_range(1, 255));
		body.push_back(chk);
		cut = (style == 3) ? $urandom_range(1, body.size() - 1) : body.size();
		for (int i = 0; i < cut; i++) begin
			put_byte(body[i]);
			if (cur_gap > 0 && $urandom_range(5) == 0)
				put_ticks((cur_gap > 4) ? $urandom_range(1, 4) : $urandom_range(1, cur_gap));
			else if ($urandom_range(79) == 0)
				put_ticks(cur_gap + 1);
		end
		if (style == 3)
			put_ticks(cur_gap + 1 + $urandom_range(1));
		else if ($urandom_range(3) == 0)
			put_ticks($urandom_range(1, 3));
	endtask

	initial begin
		arst_n          = 1'b0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		link.valid     <= 1'b0;
		link.operation <= OP_BYTE;
		link.data_byte <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// NNX, shortest frame; then NX as length, one payload byte, bad sum
		send_bytes('{HDR_FIRST, HDR_FIRST, HDR_SECOND, 8'h00, 8'h06, 8'hA5, 8'h51});
		send_bytes('{HDR_FIRST, HDR_SECOND, HDR_FIRST, HDR_SECOND, 8'h00, 8'h07,
			8'h00, 8'hFF, 8'h53});
		// zero timeout: low length byte N restarts header, aborts before and after command
		set_gap(16'd0);
		reg_write(SPARE_ADDR, 32'h0000_0007);
		send_bytes('{HDR_FIRST, HDR_SECOND, 8'hFF, HDR_FIRST, HDR_SECOND});
		put_ticks(1);
		send_bytes('{HDR_FIRST, HDR_SECOND, 8'h00, 8'h08, 8'hC3, 8'h11});
		put_ticks(1);

		tx_idle_pct  = 33;
		rx_stall_pct = 85;
		set_gap(16'd6);
		items_goal = items_sent + 300;
		while (items_sent < items_goal)
			send_frame();

		tx_idle_pct  = 85;
		rx_stall_pct = 33;
		set_gap(16'd2);
		items_goal = items_sent + 300;
		while (items_sent < items_goal)
			send_frame();

		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		set_gap(16'd40);
		hold_go <= 1'b1;
		items_goal = items_sent + 300;
		while (items_sent < items_goal)
			send_frame();

		// largest timeout keeps a frame open through idle ticks, then a short one aborts it
		set_gap(16'hFFFF);
		send_bytes('{HDR_FIRST, HDR_SECOND, 8'h00});
		put_ticks(20);
		set_gap(16'd5);
		put_ticks(1);
		settle();

		$display("%0d link items sent: hand-built frames, random frames under three idle mixes,",
			items_sent);
		$display("gap timeouts 0 to 65535; checked %0d payload, %0d ok, %0d sum errors, %0d aborts",
			payload_seen, frames_ok, sum_errors, aborts);
		if (mismatches == 0) begin
			$display("[header_length_sum_deframer] OK");
		end else begin
			$display("[header_length_sum_deframer] ERROR");
		end
		$finish;
	end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/hlsd_pkg.sv
hw/rtl/hlsd_if.sv
hw/rtl/hlsd_front.sv
hw/rtl/hlsd_queue.sv
hw/rtl/header_length_sum_deframer.sv
bench/deframer_checker.sv
bench/header_length_sum_deframer_test.sv
